[rtl/lsdrs_pkg.sv]
// Shared constants and types for the binary LSD radix sorter.
// No dependencies; the interfaces, the sequencer and the top level import this package.
`default_nettype none
package lsdrs_pkg;

	// Store capacity and value width
	localparam int MAX_ITEMS  = 64;
	localparam int VALUE_BITS = 16;

	// Derived widths: RAM index, item count (holds MAX_ITEMS), bit position
	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int BIT_W = $clog2(VALUE_BITS + 1);

	// Logical access to the two-bank store, issued by the sequencer
	typedef struct packed {
		logic                  we;
		logic                  wbank;
		logic [IDX_W-1:0]      waddr;
		logic [VALUE_BITS-1:0] wdata;
		logic                  re;
		logic                  rbank;
		logic [IDX_W-1:0]      raddr;
	} ram_req_t;

endpackage
`default_nettype wire

[rtl/lsdrs_item_if.sv]
// Input channel: valid/ready handshake carrying one value and its last mark.
// Depends on lsdrs_pkg for the value width.
`default_nettype none
interface lsdrs_item_if;
	import lsdrs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] item_value;
	logic                  is_last_in;

	modport source (output valid, item_value, is_last_in, input ready);
	modport sink (input valid, item_value, is_last_in, output ready);
endinterface
`default_nettype wire

[rtl/lsdrs_result_if.sv]
// Output channel: valid/ready handshake carrying one sorted value and flags.
// Depends on lsdrs_pkg for the value width.
`default_nettype none
interface lsdrs_result_if;
	import lsdrs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] sorted_value;
	logic                  is_last_out;
	logic                  overflow_seen;

	modport source (output valid, sorted_value, is_last_out, overflow_seen, input ready);
	modport sink (input valid, sorted_value, is_last_out, overflow_seen, output ready);
endinterface
`default_nettype wire

[rtl/lsdrs_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module lsdrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[rtl/lsdrs_seq.sv]
// Sequencer of the radix sorter: load, per-bit partition passes, emission.
// Depends on lsdrs_pkg, lsdrs_item_if and lsdrs_result_if.
`default_nettype none
module lsdrs_seq (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	lsdrs_item_if.sink                           items,
	lsdrs_result_if.source                       results,
	output lsdrs_pkg::ram_req_t                  req,
	input  wire logic [lsdrs_pkg::VALUE_BITS-1:0] rdata
);
	import lsdrs_pkg::*;

	typedef enum logic [1:0] {S_LOAD, S_CHECK, S_PASS, S_EMIT} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic [VALUE_BITS-1:0] largest_q;
	logic                  dropped_q;
	logic [BIT_W-1:0]      bit_q;
	logic                  sel_q;
	logic [CNT_W-1:0]      zc_q;
	logic [CNT_W-1:0]      zn_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic [CNT_W-1:0]      zp_q;
	logic [CNT_W-1:0]      op_q;
	logic                  rd_v_s1;
	logic                  last_s1;
	logic                  out_v_q;
	logic [VALUE_BITS-1:0] out_val_q;
	logic                  out_last_q;
	logic                  out_ovf_q;

	logic                  accept_in;
	logic                  full;
	logic                  load_we;
	logic                  pass_we;
	logic                  issue_pass;
	logic                  issue_emit;
	logic [VALUE_BITS-1:0] sh_cur;
	logic [VALUE_BITS-1:0] sh_next;
	logic                  cur_one;
	logic                  next_one;
	logic [BIT_W-1:0]      nbit_pos;
	logic [CNT_W-1:0]      one_pos;
	logic [CNT_W-1:0]      rd_idx_inc;
	logic                  more_bits;

	// Handshake and issue conditions
	always_comb begin
		items.ready = (state_q == S_LOAD);
		accept_in   = items.valid && items.ready;
		full        = (count_q == CNT_W'(MAX_ITEMS));
		load_we     = accept_in && !full;
		issue_pass  = (state_q == S_PASS) && (rd_idx_q != count_q);
		issue_emit  = (state_q == S_EMIT) && (rd_idx_q != count_q) && !rd_v_s1
			&& (!out_v_q || results.ready);
		pass_we     = rd_v_s1 && (state_q == S_PASS);
		rd_idx_inc  = rd_idx_q + CNT_W'(1);
		more_bits   = (bit_q < BIT_W'(VALUE_BITS)) && ((largest_q >> bit_q) != '0);
	end

	// Classify the read item on the current bit and on the next one
	always_comb begin
		nbit_pos = bit_q + BIT_W'(1);
		sh_cur   = rdata >> bit_q;
		sh_next  = rdata >> nbit_pos;
		cur_one  = sh_cur[0];
		next_one = sh_next[0];
		one_pos  = zc_q + op_q;
	end

	// Drive the store: loads go to bank 0, a pass moves items to the other bank
	always_comb begin
		req.we    = load_we || pass_we;
		req.re    = issue_pass || issue_emit;
		req.rbank = sel_q;
		req.raddr = rd_idx_q[IDX_W-1:0];
		if (load_we) begin
			req.wbank = 1'b0;
			req.waddr = count_q[IDX_W-1:0];
			req.wdata = items.item_value;
		end else begin
			req.wbank = ~sel_q;
			req.waddr = cur_one ? one_pos[IDX_W-1:0] : zp_q[IDX_W-1:0];
			req.wdata = rdata;
		end
	end

	// Present the output register
	always_comb begin
		results.valid         = out_v_q;
		results.sorted_value  = out_val_q;
		results.is_last_out   = out_last_q;
		results.overflow_seen = out_ovf_q;
	end

	// State, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			count_q    <= '0;
			largest_q  <= '0;
			dropped_q  <= 1'b0;
			bit_q      <= '0;
			sel_q      <= 1'b0;
			zc_q       <= '0;
			zn_q       <= '0;
			rd_idx_q   <= '0;
			zp_q       <= '0;
			op_q       <= '0;
			rd_v_s1    <= 1'b0;
			last_s1    <= 1'b0;
			out_v_q    <= 1'b0;
			out_val_q  <= '0;
			out_last_q <= 1'b0;
			out_ovf_q  <= 1'b0;
		end else begin
			rd_v_s1 <= issue_pass || issue_emit;

			// Free the output register once its transaction completes
			if (out_v_q && results.ready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				S_LOAD: begin
					if (accept_in) begin
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
							if (items.item_value > largest_q) begin
								largest_q <= items.item_value;
							end
							if (!items.item_value[0]) begin
								zc_q <= zc_q + CNT_W'(1);
							end
						end else begin
							dropped_q <= 1'b1;
						end
						if (items.is_last_in) begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					rd_idx_q <= '0;
					zp_q     <= '0;
					op_q     <= '0;
					zn_q     <= '0;
					state_q  <= more_bits ? S_PASS : S_EMIT;
				end
				S_PASS: begin
					if (issue_pass) begin
						rd_idx_q <= rd_idx_inc;
					end
					// Place the returning item and count zeros of the next bit
					if (rd_v_s1) begin
						if (cur_one) begin
							op_q <= op_q + CNT_W'(1);
						end else begin
							zp_q <= zp_q + CNT_W'(1);
						end
						if (!next_one) begin
							zn_q <= zn_q + CNT_W'(1);
						end
					end else if (!issue_pass) begin
						// Pass drained: advance to the next bit, swap banks
						bit_q   <= nbit_pos;
						sel_q   <= ~sel_q;
						zc_q    <= zn_q;
						state_q <= S_CHECK;
					end
				end
				S_EMIT: begin
					if (issue_emit) begin
						rd_idx_q <= rd_idx_inc;
						last_s1  <= (rd_idx_inc == count_q);
					end
					if (rd_v_s1) begin
						out_v_q    <= 1'b1;
						out_val_q  <= rdata;
						out_last_q <= last_s1;
						out_ovf_q  <= dropped_q;
						// Final item placed in the output register: start a new set
						if (last_s1) begin
							state_q   <= S_LOAD;
							count_q   <= '0;
							largest_q <= '0;
							dropped_q <= 1'b0;
							zc_q      <= '0;
							bit_q     <= '0;
							sel_q     <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/binary_lsd_radix_sorter_core.sv]
// Top level of the binary LSD radix sorter: sequencer and two store banks.
// Depends on lsdrs_pkg, lsdrs_item_if, lsdrs_result_if, lsdrs_ram, lsdrs_seq.
//
// Values are loaded one per cycle into a 64-entry store until a transaction
// marked last arrives; values beyond 64 are dropped and reported through
// overflow_seen on every result of that set. The set is then sorted by one
// stable partition pass per bit, from bit zero up to the highest set bit of
// the largest value, moving the items between two RAM banks that each have one
// read and one write port. A set is loaded item by item, then runs P passes
// (0 to 16), each with a setup step in S_CHECK, one RAM read per item and
// steps to place the last item and close the pass, then a decision step in
// S_CHECK, then emission, which waits while the output side is not ready; the
// RAM read port sets the per-item cost of each pass. No input is taken from
// the last input until the final sorted value has been placed in the output
// register.
`default_nettype none
module binary_lsd_radix_sorter_core (
	input wire logic       clk,
	input wire logic       arst_n,
	lsdrs_item_if.sink     items,
	lsdrs_result_if.source results
);
	import lsdrs_pkg::*;

	ram_req_t              req;
	logic [VALUE_BITS-1:0] rdata;
	logic [VALUE_BITS-1:0] rdata0;
	logic [VALUE_BITS-1:0] rdata1;
	logic                  rbank_q;
	logic                  we0;
	logic                  we1;

	// Sequencer
	lsdrs_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.req     (req),
		.rdata   (rdata)
	);

	// Steer writes to one bank
	assign we0 = req.we && !req.wbank;
	assign we1 = req.we && req.wbank;

	lsdrs_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (req.waddr),
		.wdata (req.wdata),
		.raddr (req.raddr),
		.rdata (rdata0)
	);

	lsdrs_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (req.waddr),
		.wdata (req.wdata),
		.raddr (req.raddr),
		.rdata (rdata1)
	);

	// Select read data by a registered copy of the read bank, matching the registered RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rbank_q <= 1'b0;
		end else begin
			rbank_q <= req.rbank;
		end
	end

	assign rdata = rbank_q ? rdata1 : rdata0;

	// A pass never writes the bank it is reading
	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		(req.we && req.re) |-> (req.wbank != req.rbank))
		else $error("read and write hit the same bank");

	// Loading resumes only with the final result (or nothing) in the output register
	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(items.ready) |-> (!results.valid || results.is_last_out))
		else $error("input reopened before the final result");

	// No input is taken while a set is still being emitted
	a_no_load_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.is_last_out) |-> !items.ready)
		else $error("input open during emission");

endmodule
`default_nettype wire

[sim/tb_binary_lsd_radix_sorter_core.sv]
// Self-checking testbench for binary_lsd_radix_sorter_core: directed and random value sets.
// Depends on lsdrs_pkg, lsdrs_item_if, lsdrs_result_if and the sorter RTL.
module tb_binary_lsd_radix_sorter_core;
	timeunit 1ns;
	timeprecision 1ps;
	import lsdrs_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RANDOM_ITEMS  = 190;
	localparam int TAIL_ITEMS    = 30;
	localparam int STALL_LIMIT   = 6000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int PRINT_CAP     = 60;
	localparam int N_DIRECTED    = 20;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  last;
		logic                  ovf;
	} sorted_rec_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  last;
		logic                  typed;
		sorted_rec_t           want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	lsdrs_item_if   items_ch ();
	lsdrs_result_if results_ch ();

	binary_lsd_radix_sorter_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch)
	);

	// Sorter shadow state for the set being loaded
	logic [VALUE_BITS-1:0] held_values[$];
	logic [VALUE_BITS-1:0] held_max;
	logic                  held_drop;

	sorted_rec_t expected_sorted[$];
	int          err_count;
	int          stalled_cycles;
	int          stall_left;
	int          result_stall_pct;
	bit          steady_tail;
	sorted_rec_t got;
	sorted_rec_t want;

	// Directed sets: single-value sets carry a typed result, the rest go through the predictor
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 1'b1, 1'b0}},
		'{16'h0000, 1'b1, 1'b1, '{16'h0000, 1'b1, 1'b0}},
		'{16'h0001, 1'b1, 1'b1, '{16'h0001, 1'b1, 1'b0}},
		'{16'h0000, 1'b0, 1'b0, '0},
		'{16'h0000, 1'b0, 1'b0, '0},
		'{16'h0000, 1'b1, 1'b0, '0},
		'{16'h8000, 1'b0, 1'b0, '0},
		'{16'h0001, 1'b0, 1'b0, '0},
		'{16'hFFFF, 1'b0, 1'b0, '0},
		'{16'h0000, 1'b0, 1'b0, '0},
		'{16'h8000, 1'b0, 1'b0, '0},
		'{16'h7FFF, 1'b1, 1'b0, '0},
		'{16'h0005, 1'b0, 1'b0, '0},
		'{16'h0003, 1'b1, 1'b0, '0},
		'{16'h8000, 1'b0, 1'b0, '0},
		'{16'h0000, 1'b1, 1'b0, '0},
		'{16'h00FF, 1'b0, 1'b0, '0},
		'{16'h0100, 1'b0, 1'b0, '0},
		'{16'h00FF, 1'b0, 1'b0, '0},
		'{16'h0101, 1'b1, 1'b0, '0}
	};

	// Clock
	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// Take one value into the shadow set; on the last one, sort by bit passes and emit
	function automatic void load_and_sort(input logic [VALUE_BITS-1:0] v, input logic lst,
			output sorted_rec_t res[$]);
		logic [VALUE_BITS-1:0] zeros[$];
		logic [VALUE_BITS-1:0] ones[$];
		sorted_rec_t rec;
		res.delete();
		if (held_values.size() < MAX_ITEMS) begin
			held_values.push_back(v);
			if (v > held_max)
				held_max = v;
		end else begin
			held_drop = 1'b1;
		end
		if (!lst)
			return;
		for (int b = 0; b < VALUE_BITS && (held_max >> b) != 0; b++) begin
			zeros.delete();
			ones.delete();
			foreach (held_values[i]) begin
				if (held_values[i][b])
					ones.push_back(held_values[i]);
				else
					zeros.push_back(held_values[i]);
			end
			held_values = {zeros, ones};
		end
		foreach (held_values[i]) begin
			rec.value = held_values[i];
			rec.last  = (i == held_values.size() - 1);
			rec.ovf   = held_drop;
			res.push_back(rec);
		end
		held_values.delete();
		held_max  = '0;
		held_drop = 1'b0;
	endfunction

	// Drive one value, with an optional idle burst ahead of it, and wait for the transaction
	task automatic send_value(input logic [VALUE_BITS-1:0] v, input logic lst, input int gap_pct,
			output sorted_rec_t res[$]);
		@(negedge clk);
		if (!steady_tail && $urandom_range(0, 99) < gap_pct) begin
			items_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		items_ch.valid      <= 1'b1;
		items_ch.item_value <= v;
		items_ch.is_last_in <= lst;
		@(posedge clk);
		while (!items_ch.ready)
			@(posedge clk);
		load_and_sort(v, lst, res);
	endtask

	function automatic logic [VALUE_BITS-1:0] pick_value(input int flavor);
		case (flavor)
			0: return VALUE_BITS'($urandom_range(0, 15));
			1: return VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1);
			2: return ($urandom_range(0, 1) != 0) ? '1 : '0;
			default: return VALUE_BITS'($urandom_range(0, 65535));
		endcase
	endfunction

	// Result side: hold ready low in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			results_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!steady_tail && $urandom_range(0, 99) < result_stall_pct) begin
			results_ch.ready <= 1'b0;
			stall_left <= $urandom_range(1, 14) - 1;
		end else begin
			results_ch.ready <= 1'b1;
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready) begin
			got.value = results_ch.sorted_value;
			got.last  = results_ch.is_last_out;
			got.ovf   = results_ch.overflow_seen;
			if (expected_sorted.size() == 0) begin
				if (err_count < PRINT_CAP)
					$display("%0t: unexpected result, expected none, actual value=%h last=%b ovf=%b",
						$time, got.value, got.last, got.ovf);
				err_count++;
			end else begin
				want = expected_sorted.pop_front();
				if (got.value !== want.value) begin
					if (err_count < PRINT_CAP)
						$display("%0t: sorted_value expected %h actual %h",
							$time, want.value, got.value);
					err_count++;
				end
				if (got.last !== want.last) begin
					if (err_count < PRINT_CAP)
						$display("%0t: is_last_out expected %b actual %b",
							$time, want.last, got.last);
					err_count++;
				end
				if (got.ovf !== want.ovf) begin
					if (err_count < PRINT_CAP)
						$display("%0t: overflow_seen expected %b actual %b",
							$time, want.ovf, got.ovf);
					err_count++;
				end
			end
		end
	end

	// Watchdog: end the run after too long without any transaction
	always @(posedge clk) begin
		if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Stimulus
	initial begin
		sorted_rec_t res[$];
		int sent;
		int set_no;
		int set_len;
		int flavor;
		int gap_pct;

		arst_n              = 1'b0;
		items_ch.valid      = 1'b0;
		items_ch.item_value = '0;
		items_ch.is_last_in = 1'b0;
		results_ch.ready    = 1'b0;
		held_max            = '0;
		held_drop           = 1'b0;
		err_count           = 0;
		stalled_cycles      = 0;
		stall_left          = 0;
		result_stall_pct    = 20;
		steady_tail         = 1'b0;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed sets: extremes, all-zero set, duplicates, top bit only
		foreach (directed_rows[r]) begin
			send_value(directed_rows[r].value, directed_rows[r].last, 20, res);
			if (directed_rows[r].typed)
				expected_sorted.push_back(directed_rows[r].want);
			else
				foreach (res[i]) expected_sorted.push_back(res[i]);
		end

		// Hold the sender until every sorted value has come back
		@(negedge clk);
		items_ch.valid <= 1'b0;
		wait (expected_sorted.size() == 0);

		// Random sets: mostly short, one exactly full, one past capacity
		sent   = 0;
		set_no = 0;
		while (sent < RANDOM_ITEMS) begin
			if (set_no == 2)
				set_len = MAX_ITEMS;
			else if (set_no == 6)
				set_len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
			else
				set_len = $urandom_range(1, 7);
			flavor = $urandom_range(0, 5);
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 25;
				default: gap_pct = 60;
			endcase
			case ($urandom_range(0, 2))
				0: result_stall_pct = 0;
				1: result_stall_pct = 15;
				default: result_stall_pct = 50;
			endcase
			for (int k = 0; k < set_len; k++) begin
				steady_tail = (sent >= RANDOM_ITEMS - TAIL_ITEMS);
				send_value(pick_value(flavor), k == set_len - 1, gap_pct, res);
				foreach (res[i]) expected_sorted.push_back(res[i]);
				sent++;
			end
			set_no++;
		end

		// Drain and finish
		@(negedge clk);
		items_ch.valid <= 1'b0;
		wait (expected_sorted.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

[files.f]
rtl/lsdrs_pkg.sv
rtl/lsdrs_item_if.sv
rtl/lsdrs_result_if.sv
rtl/lsdrs_ram.sv
rtl/lsdrs_seq.sv
rtl/binary_lsd_radix_sorter_core.sv
sim/tb_binary_lsd_radix_sorter_core.sv
